FILE: rtl/scef_pkg.sv
// shared types and constants for the strong connectivity edge flip block
`default_nettype none
package scef_pkg;

	localparam int FIELD_W = 6;
	localparam int CFG_W   = 7;

	// result codes
	localparam logic [1:0] VERDICT_CONNECTED = 2'd0;
	localparam logic [1:0] VERDICT_FIXED     = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] road_start;
		logic [FIELD_W-1:0] road_end;
		logic               carries_road;
		logic               final_road;
	} scef_item_t;

	typedef struct packed {
		logic [1:0]         verdict;
		logic [FIELD_W-1:0] flipped_start;
		logic [FIELD_W-1:0] flipped_end;
	} scef_result_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_WALK,
		ST_FETCH,
		ST_ARM,
		ST_DONE
	} scef_state_t;

endpackage
`default_nettype wire

FILE: rtl/scef_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module scef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read returns the contents before a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/strong_connectivity_edge_flip.sv
// top level of the strong connectivity check with single road reversal
`default_nettype none
// Roads are loaded one transaction per cycle into an adjacency memory (one row per node,
// one bit per destination) and a road list. A transaction with final_road set ends the
// graph: the block then raises item_stall and runs the check on one shared row unit that
// reads one adjacency row per cycle from the single read port. A walk pass reads the rows
// of the n active nodes in order, and a walk repeats passes until nothing new is reached
// (at most n passes), once forward from node 0 and, only if that reaches every node, once
// backward. The plain graph is checked first; if it fails, each stored road is tried
// reversed in load order until one connects the graph: the road is fetched (ST_FETCH,
// ST_ARM) and then walked as above. The trial reversal is applied on the read path, so the
// stored adjacency is never modified. After the result is handed to the output register
// the adjacency is cleared through per-row valid bits and loading resumes; a finished
// result may wait on result_stall while new roads load.
module strong_connectivity_edge_flip #(
	parameter int MAX_NODES = 64,
	parameter int MAX_ROADS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  scef_pkg::scef_item_t           item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output scef_pkg::scef_result_t         result,
	input  logic                           cfg_wr_en,
	input  logic [scef_pkg::CFG_W-1:0]     cfg_wr_data
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int RAW = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
	localparam int RCW = $clog2(MAX_ROADS + 1);
	localparam int RLW = 2 * scef_pkg::FIELD_W;

	scef_pkg::scef_state_t state_q, state_d;

	// configuration
	logic [scef_pkg::CFG_W-1:0] node_count_q;
	logic [NCW-1:0]             n_eff;
	logic [MAX_NODES-1:0]       all_mask;

	// load path
	logic                 accept;
	logic                 store_ok;
	logic [RCW-1:0]       road_total_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic                 ld_v_s1;
	logic [NW-1:0]        ld_row_s1;
	logic [NW-1:0]        ld_col_s1;
	logic                 byp_v_q;
	logic [NW-1:0]        byp_row_q;
	logic [MAX_NODES-1:0] byp_data_q;
	logic [MAX_NODES-1:0] ld_base;
	logic [MAX_NODES-1:0] ld_wdata;

	// adjacency memory ports
	logic [NW-1:0]        adj_raddr;
	logic [MAX_NODES-1:0] adj_rdata;

	// road list memory ports
	logic [RLW-1:0]       road_rdata;

	// walk unit
	logic [NCW-1:0]       rd_idx_q;
	logic                 issue;
	logic                 v_s1;
	logic [NW-1:0]        idx_s1;
	logic [MAX_NODES-1:0] reached_q;
	logic [MAX_NODES-1:0] reached_nxt;
	logic                 grew_q;
	logic                 grew_now;
	logic                 dir_q;
	logic [MAX_NODES-1:0] row_eff;
	logic                 pass_end;
	logic                 walk_end;
	logic                 covered;
	logic                 to_bwd;
	logic                 trial_done;
	logic                 trial_ok;
	logic                 start_walk;

	// trial control
	logic                       flip_on_q;
	logic [scef_pkg::FIELD_W-1:0] flip_s_q;
	logic [scef_pkg::FIELD_W-1:0] flip_e_q;
	logic [RCW-1:0]             trial_k_q;
	logic [RCW-1:0]             next_k;
	logic                       trials_left;

	// pending answer and output register
	scef_pkg::scef_result_t pend_q;
	scef_pkg::scef_result_t result_q;
	logic                   result_valid_q;
	logic                   out_load;

	// node count register, to be written only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= scef_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			node_count_q <= cfg_wr_data;
		end
	end

	// zero acts as one, anything above the node capacity acts as the capacity
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NCW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_eff = NCW'(MAX_NODES);
		end else begin
			n_eff = NCW'(node_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			all_mask[i] = (i < 32'(n_eff));
		end
	end

	// road acceptance filter: a road is carried, endpoints inside capacity and room in the list
	assign store_ok = item.carries_road
		&& (32'(item.road_start) < MAX_NODES)
		&& (32'(item.road_end) < MAX_NODES)
		&& (32'(road_total_q) < MAX_ROADS);

	// ---------------------------------------------------------------
	// walk unit: one adjacency row per cycle against the reached set
	// ---------------------------------------------------------------

	// trial reversal applied on the read path: drop s->e, add e->s
	always_comb begin
		row_eff = row_valid_q[idx_s1] ? adj_rdata : '0;
		if (flip_on_q && (idx_s1 == flip_s_q[NW-1:0])) begin
			row_eff[flip_e_q[NW-1:0]] = 1'b0;
		end
		if (flip_on_q && (idx_s1 == flip_e_q[NW-1:0])) begin
			row_eff[flip_s_q[NW-1:0]] = 1'b1;
		end
	end

	always_comb begin
		reached_nxt = reached_q;
		if (v_s1) begin
			if (!dir_q) begin
				// forward: a reached node spreads to its successors
				if (reached_q[idx_s1]) begin
					reached_nxt = reached_q | (row_eff & all_mask);
				end
			end else begin
				// backward: a node with an edge into the set joins it
				if (!reached_q[idx_s1] && (|(row_eff & reached_q))) begin
					reached_nxt = reached_q | (MAX_NODES'(1) << idx_s1);
				end
			end
		end
	end

	assign grew_now   = (reached_nxt != reached_q);
	assign issue      = (state_q == scef_pkg::ST_WALK) && (rd_idx_q < n_eff);
	assign pass_end   = (state_q == scef_pkg::ST_WALK) && v_s1
		&& (32'(idx_s1) == (32'(n_eff) - 1));
	assign walk_end   = pass_end && !(grew_q || grew_now);
	assign covered    = (reached_nxt == all_mask);
	assign to_bwd     = walk_end && !dir_q && covered;
	assign trial_done = walk_end && !to_bwd;
	assign trial_ok   = trial_done && covered;

	assign next_k      = flip_on_q ? (trial_k_q + RCW'(1)) : '0;
	assign trials_left = (next_k != road_total_q);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			scef_pkg::ST_LOAD: begin
				if (item_valid && item.final_road) begin
					state_d = scef_pkg::ST_DRAIN;
				end
			end
			scef_pkg::ST_DRAIN: begin
				state_d = scef_pkg::ST_WALK;
			end
			scef_pkg::ST_WALK: begin
				if (trial_done) begin
					if (trial_ok || !trials_left) begin
						state_d = scef_pkg::ST_DONE;
					end else begin
						state_d = scef_pkg::ST_FETCH;
					end
				end
			end
			scef_pkg::ST_FETCH: begin
				state_d = scef_pkg::ST_ARM;
			end
			scef_pkg::ST_ARM: begin
				state_d = scef_pkg::ST_WALK;
			end
			scef_pkg::ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					state_d = scef_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = scef_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		start_walk = 1'b0;
		out_load   = 1'b0;
		adj_raddr  = rd_idx_q[NW-1:0];
		case (state_q)
			scef_pkg::ST_LOAD: begin
				item_stall = 1'b0;
				adj_raddr  = item.road_start[NW-1:0];
			end
			scef_pkg::ST_DRAIN: begin
				start_walk = 1'b1;
			end
			scef_pkg::ST_WALK: begin
				start_walk = to_bwd;
			end
			scef_pkg::ST_ARM: begin
				start_walk = 1'b1;
			end
			scef_pkg::ST_DONE: begin
				out_load = !result_valid_q || !result_stall;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scef_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// load path: read-modify-write of one adjacency row per road
	// ---------------------------------------------------------------

	// a write committed in the previous cycle is not yet in the read data
	always_comb begin
		if (byp_v_q && (byp_row_q == ld_row_s1)) begin
			ld_base = byp_data_q;
		end else if (row_valid_q[ld_row_s1]) begin
			ld_base = adj_rdata;
		end else begin
			ld_base = '0;
		end
		ld_wdata = ld_base | (MAX_NODES'(1) << ld_col_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1      <= 1'b0;
			byp_v_q      <= 1'b0;
			road_total_q <= '0;
			row_valid_q  <= '0;
		end else begin
			ld_v_s1 <= accept && store_ok;
			byp_v_q <= ld_v_s1;
			if (accept && store_ok) begin
				road_total_q <= road_total_q + RCW'(1);
			end else if (out_load) begin
				road_total_q <= '0;
			end
			if (ld_v_s1) begin
				row_valid_q[ld_row_s1] <= 1'b1;
			end else if (out_load) begin
				row_valid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ld_row_s1  <= item.road_start[NW-1:0];
		ld_col_s1  <= item.road_end[NW-1:0];
		byp_row_q  <= ld_row_s1;
		byp_data_q <= ld_wdata;
	end

	scef_ram #(
		.WIDTH (MAX_NODES),
		.DEPTH (MAX_NODES)
	) u_adj_ram (
		.clk     (clk),
		.wr_en   (ld_v_s1),
		.wr_addr (ld_row_s1),
		.wr_data (ld_wdata),
		.rd_addr (adj_raddr),
		.rd_data (adj_rdata)
	);

	scef_ram #(
		.WIDTH (RLW),
		.DEPTH (MAX_ROADS)
	) u_road_ram (
		.clk     (clk),
		.wr_en   (accept && store_ok),
		.wr_addr (road_total_q[RAW-1:0]),
		.wr_data ({item.road_start, item.road_end}),
		.rd_addr (trial_k_q[RAW-1:0]),
		.rd_data (road_rdata)
	);

	// ---------------------------------------------------------------
	// walk and trial registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			grew_q    <= 1'b0;
			dir_q     <= 1'b0;
			flip_on_q <= 1'b0;
			trial_k_q <= '0;
		end else begin
			v_s1 <= issue;
			if (start_walk) begin
				rd_idx_q <= '0;
				grew_q   <= 1'b0;
				dir_q    <= to_bwd;
			end else if (pass_end) begin
				// another pass only if this one reached something new
				rd_idx_q <= '0;
				grew_q   <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + NCW'(1);
				end
				grew_q <= grew_q || grew_now;
			end
			if (state_q == scef_pkg::ST_DRAIN) begin
				flip_on_q <= 1'b0;
			end else if (state_q == scef_pkg::ST_ARM) begin
				flip_on_q <= 1'b1;
			end
			if (trial_done && !trial_ok) begin
				trial_k_q <= next_k;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[NW-1:0];
		if (start_walk) begin
			reached_q <= MAX_NODES'(1);
		end else begin
			reached_q <= reached_nxt;
		end
		if (state_q == scef_pkg::ST_ARM) begin
			flip_s_q <= road_rdata[RLW-1:scef_pkg::FIELD_W];
			flip_e_q <= road_rdata[scef_pkg::FIELD_W-1:0];
		end
		if (trial_done) begin
			if (trial_ok && flip_on_q) begin
				pend_q.verdict       <= scef_pkg::VERDICT_FIXED;
				pend_q.flipped_start <= flip_s_q;
				pend_q.flipped_end   <= flip_e_q;
			end else begin
				pend_q.verdict       <= trial_ok ? scef_pkg::VERDICT_CONNECTED
					: scef_pkg::VERDICT_INVALID;
				pend_q.flipped_start <= '0;
				pend_q.flipped_end   <= '0;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

FILE: rtl/scef_checker.sv
// port level checker for the strong connectivity edge flip block and its bind
`default_nettype none
module scef_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_stall,
	input scef_pkg::scef_item_t           item,
	input logic                           result_valid,
	input logic                           result_stall,
	input scef_pkg::scef_result_t         result
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// only the three defined verdict codes appear
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.verdict == scef_pkg::VERDICT_CONNECTED)
			|| (result.verdict == scef_pkg::VERDICT_FIXED)
			|| (result.verdict == scef_pkg::VERDICT_INVALID))
		else $error("undefined verdict code");

	// road fields are zero unless a reversal fixed the graph
	a_flip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.verdict != scef_pkg::VERDICT_FIXED)
			|-> (result.flipped_start == '0) && (result.flipped_end == '0))
		else $error("flipped road reported without a fix");

	// the check starts right after the last road of a graph
	a_busy_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.final_road |=> item_stall)
		else $error("block not busy after final transaction");

endmodule

bind strong_connectivity_edge_flip scef_checker u_scef_checker (.*);
`default_nettype wire

FILE: tb/strong_connectivity_edge_flip_test.sv
// self-checking testbench for the strong connectivity edge flip block
`default_nettype none
module strong_connectivity_edge_flip_test;

	localparam int NODE_CAP = 64;
	localparam int ROAD_CAP = 256;
	localparam int ITEM_GOAL = 600;
	localparam int NODE_W = scef_pkg::FIELD_W;
	localparam int CFG_BITS = scef_pkg::CFG_W;
	// cycles allowed for the adjacency clear after a verdict leaves
	localparam int SETTLE = 8;
	localparam int TAIL = 50;
	// limit for the whole run, enforced by the watchdog
	localparam int CYCLE_LIMIT = 5_000_000;

	// directed rows: no register write, and whether the verdict is typed in
	localparam int NO_CFG = -1;
	localparam bit BY_MODEL = 1'b0;
	localparam bit KNOWN = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
	} road_t;

	typedef struct packed {
		logic                   set_cfg;
		logic [CFG_BITS-1:0]    cfg;
		scef_pkg::scef_item_t   it;
		logic                   typed;
		scef_pkg::scef_result_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	scef_pkg::scef_item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	scef_pkg::scef_result_t result;
	logic cfg_wr_en;
	logic [CFG_BITS-1:0] cfg_wr_data;

	strong_connectivity_edge_flip #(
		.MAX_NODES(NODE_CAP),
		.MAX_ROADS(ROAD_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// private copy of the graph as the block should hold it
	logic [NODE_CAP-1:0] adj_rows [NODE_CAP];
	road_t road_log [$];
	logic [CFG_BITS-1:0] node_setting = 7'd1;

	// directed stimulus table
	step_t plan [$];

	// verdicts still owed by the block, oldest first
	scef_pkg::scef_result_t pending_verdicts [$];
	scef_pkg::scef_result_t want_now;
	int mismatches = 0;
	int counted = 0;
	int stall_left = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	// register value 0 behaves as one node, anything past the cap as the cap
	function automatic int live_nodes();
		int n;
		n = node_setting;
		if (n < 1) n = 1;
		if (n > NODE_CAP) n = NODE_CAP;
		return n;
	endfunction

	// closure from node 0, along roads or against them
	function automatic bit spreads_to_all(int n, logic [NODE_CAP-1:0] full_set, bit backward);
		logic [NODE_CAP-1:0] seen;
		logic [NODE_CAP-1:0] nxt;
		bit grew;
		seen = 64'd1;
		grew = 1'b1;
		while (grew) begin
			grew = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!backward) begin
					if (seen[i]) begin
						nxt = (seen | adj_rows[i]) & full_set;
						if (nxt != seen) begin
							seen = nxt;
							grew = 1'b1;
						end
					end
				end else if (!seen[i] && (adj_rows[i] & seen) != '0) begin
					seen[i] = 1'b1;
					grew = 1'b1;
				end
			end
		end
		return seen == full_set;
	endfunction

	function automatic bit strongly_linked();
		int n;
		logic [NODE_CAP-1:0] full_set;
		n = live_nodes();
		full_set = (n >= NODE_CAP) ? '1 : ((64'd1 << n) - 64'd1);
		return spreads_to_all(n, full_set, 1'b0) && spreads_to_all(n, full_set, 1'b1);
	endfunction

	// plain check, then each stored road reversed in load order until one fixes the graph
	function automatic scef_pkg::scef_result_t judge_graph();
		scef_pkg::scef_result_t res;
		logic [NODE_CAP-1:0] row_s;
		logic [NODE_CAP-1:0] row_e;
		int s;
		int e;
		bit ok;
		res = '0;
		res.verdict = scef_pkg::VERDICT_INVALID;
		if (strongly_linked()) begin
			res.verdict = scef_pkg::VERDICT_CONNECTED;
			return res;
		end
		for (int k = 0; k < road_log.size(); k++) begin
			s = road_log[k].from_node;
			e = road_log[k].to_node;
			row_s = adj_rows[s];
			row_e = adj_rows[e];
			// a self loop clears and sets the same bit, so it stays
			adj_rows[s][e] = 1'b0;
			adj_rows[e][s] = 1'b1;
			ok = strongly_linked();
			adj_rows[s] = row_s;
			adj_rows[e] = row_e;
			if (ok) begin
				res.verdict = scef_pkg::VERDICT_FIXED;
				res.flipped_start = s[NODE_W-1:0];
				res.flipped_end = e[NODE_W-1:0];
				break;
			end
		end
		return res;
	endfunction

	// fold one accepted transaction into the graph, returns 1 when a verdict is due
	function automatic bit absorb_item(input scef_pkg::scef_item_t it,
			output scef_pkg::scef_result_t res);
		road_t r;
		res = '0;
		if (it.carries_road && road_log.size() < ROAD_CAP) begin
			adj_rows[it.road_start][it.road_end] = 1'b1;
			r.from_node = it.road_start;
			r.to_node = it.road_end;
			road_log.insert(road_log.size(), r);
		end
		if (!it.final_road) return 1'b0;
		res = judge_graph();
		foreach (adj_rows[i]) adj_rows[i] = '0;
		road_log.delete();
		return 1'b1;
	endfunction

	// mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic scef_pkg::scef_item_t road_item(int s, int e, bit fin);
		scef_pkg::scef_item_t it;
		it.road_start = s[NODE_W-1:0];
		it.road_end = e[NODE_W-1:0];
		it.carries_road = 1'b1;
		it.final_road = fin;
		return it;
	endfunction

	// append one row to the directed table
	function automatic void add_step(int cfg, int s, int e, bit c, bit f, bit typed,
			logic [1:0] verdict);
		step_t row;
		row = '0;
		row.set_cfg = (cfg >= 0);
		row.cfg = cfg[CFG_BITS-1:0];
		row.it = road_item(s, e, f);
		row.it.carries_road = c;
		row.typed = typed;
		row.want.verdict = verdict;
		plan.insert(plan.size(), row);
	endfunction

	// drives the transaction and returns once the block has taken it
	task automatic push_item(input scef_pkg::scef_item_t it, input bit typed,
			input scef_pkg::scef_result_t want);
		scef_pkg::scef_result_t res;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			item_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		// transactions with neither a road nor the final mark are just ignored
		if (it.carries_road || it.final_road) counted++;
		if (absorb_item(it, res))
			pending_verdicts.insert(pending_verdicts.size(), typed ? want : res);
	endtask

	// hold off the sender until every verdict is in and the clear is done
	task automatic quiesce();
		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_nodes(input logic [CFG_BITS-1:0] v);
		quiesce();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		node_setting = v;
	endtask

	task automatic send_graph(input road_t roads [$], input bit split_final);
		scef_pkg::scef_item_t it;
		for (int i = 0; i < roads.size(); i++) begin
			if ($urandom_range(0, 9) == 0) push_item('0, 1'b0, '0);
			it = road_item(roads[i].from_node, roads[i].to_node,
				!split_final && i == roads.size() - 1);
			push_item(it, 1'b0, '0);
		end
		if (split_final || roads.size() == 0) begin
			it = '0;
			it.final_road = 1'b1;
			push_item(it, 1'b0, '0);
		end
	endtask

	// mostly small graphs, a few at or past the node cap
	function automatic logic [CFG_BITS-1:0] pick_setting();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 7'd0;
		if (r < 8) return 7'd1;
		if (r < 86) return CFG_BITS'($urandom_range(2, 10));
		if (r < 93) return CFG_BITS'($urandom_range(11, 14));
		if (r < 97) return 7'd64;
		return CFG_BITS'($urandom_range(65, 127));
	endfunction

	task automatic random_graph();
		road_t roads [$];
		int perm [$];
		road_t r;
		int n;
		int kind;
		int j;
		int tmp;
		n = live_nodes();
		if (n > 16) begin
			// big graphs stay cheap: an ordered ring, or a handful of roads
			kind = $urandom_range(0, 2);
			if (kind < 2) begin
				for (int i = 0; i < n; i++) begin
					r.from_node = i[NODE_W-1:0];
					r.to_node = NODE_W'((i + 1) % n);
					roads.insert(roads.size(), r);
				end
				// closing road loaded backwards, only its own reversal fixes it
				if (kind == 1) begin
					r = roads[n-1];
					roads[n-1].from_node = r.to_node;
					roads[n-1].to_node = r.from_node;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					r.from_node = NODE_W'($urandom_range(0, 63));
					r.to_node = NODE_W'($urandom_range(0, 63));
					roads.insert(roads.size(), r);
				end
			end
		end else begin
			kind = $urandom_range(0, 9);
			for (int i = 0; i < n; i++) perm.insert(perm.size(), i);
			for (int i = n - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			if (kind <= 3 || kind == 9) begin
				// ring through a random order of the nodes
				for (int i = 0; i < n; i++) begin
					r.from_node = NODE_W'(perm[i]);
					r.to_node = NODE_W'(perm[(i + 1) % n]);
					roads.insert(roads.size(), r);
				end
				if (kind >= 1 && kind <= 3) begin
					j = $urandom_range(0, n - 1);
					r = roads[j];
					roads[j].from_node = r.to_node;
					roads[j].to_node = r.from_node;
				end
				if (kind == 9) void'(roads.pop_back());
				if (kind == 0) begin
					repeat ($urandom_range(0, n / 2)) begin
						r.from_node = NODE_W'($urandom_range(0, n - 1));
						r.to_node = NODE_W'($urandom_range(0, n - 1));
						roads.insert(roads.size(), r);
					end
				end
				// road into a node the walks never visit
				if (kind == 3 && n < NODE_CAP) begin
					r.from_node = NODE_W'($urandom_range(0, n - 1));
					r.to_node = NODE_W'($urandom_range(n, 63));
					roads.insert(roads.size(), r);
				end
			end else if (kind <= 6) begin
				repeat ($urandom_range(1, 2 * n)) begin
					r.from_node = NODE_W'($urandom_range(0, n - 1));
					r.to_node = NODE_W'($urandom_range(0, n - 1));
					roads.insert(roads.size(), r);
				end
			end else if (kind == 7) begin
				// endpoints anywhere in the field range
				repeat ($urandom_range(1, n)) begin
					r.from_node = NODE_W'($urandom_range(0, 63));
					r.to_node = NODE_W'($urandom_range(0, 63));
					roads.insert(roads.size(), r);
				end
			end
			// kind 8 leaves the graph empty
			for (int i = roads.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				r = roads[i];
				roads[i] = roads[j];
				roads[j] = r;
			end
		end
		send_graph(roads, $urandom_range(0, 3) == 0);
	endtask

	// fill the road list, then two roads that would connect it but must be dropped
	task automatic overflow_graph();
		road_t roads [$];
		road_t r;
		set_nodes(7'd2);
		repeat (ROAD_CAP) begin
			r.from_node = NODE_W'($urandom_range(0, 1));
			r.to_node = r.from_node;
			roads.insert(roads.size(), r);
		end
		r.from_node = 6'd0;
		r.to_node = 6'd1;
		roads.insert(roads.size(), r);
		r.from_node = 6'd1;
		r.to_node = 6'd0;
		roads.insert(roads.size(), r);
		send_graph(roads, 1'b0);
	endtask

	// result side: compare each taken verdict, then decide the next stall
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %p", $time, result);
				mismatches++;
			end else begin
				want_now = pending_verdicts.pop_front();
				if (result.verdict !== want_now.verdict) begin
					$display("%0t verdict: expected %0d, actual %0d", $time,
						want_now.verdict, result.verdict);
					mismatches++;
				end
				if (result.flipped_start !== want_now.flipped_start) begin
					$display("%0t flipped_start: expected %0d, actual %0d", $time,
						want_now.flipped_start, result.flipped_start);
					mismatches++;
				end
				if (result.flipped_end !== want_now.flipped_end) begin
					$display("%0t flipped_end: expected %0d, actual %0d", $time,
						want_now.flipped_end, result.flipped_end);
					mismatches++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 2) == 0) begin
			stall_left = idle_len() - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		bit overflow_done;
		overflow_done = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		foreach (adj_rows[i]) adj_rows[i] = '0;

		// directed transactions; register writes happen before the row that carries them
		// empty graph right after reset, one node
		add_step(NO_CFG, 0, 0, 0, 1, KNOWN, scef_pkg::VERDICT_CONNECTED);
		// neither road nor final mark: no verdict
		add_step(NO_CFG, 0, 0, 0, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		// one-way road closed by an empty marker
		add_step(2, 0, 1, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 0, 0, 0, 1, KNOWN, scef_pkg::VERDICT_INVALID);
		// two nodes both ways
		add_step(NO_CFG, 0, 1, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 1, 0, 1, 1, KNOWN, scef_pkg::VERDICT_CONNECTED);
		// triangle that the last road's reversal closes
		add_step(3, 0, 1, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 1, 2, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 0, 2, 1, 1, BY_MODEL, scef_pkg::VERDICT_INVALID);
		// node count zero behaves as one node
		add_step(0, 0, 5, 1, 1, KNOWN, scef_pkg::VERDICT_CONNECTED);
		// self loop
		add_step(2, 0, 0, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 0, 1, 1, 1, BY_MODEL, scef_pkg::VERDICT_INVALID);
		// repeated road, one reversal drops both copies
		add_step(NO_CFG, 1, 0, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 1, 0, 1, 1, BY_MODEL, scef_pkg::VERDICT_INVALID);
		// road into a node past the count
		add_step(NO_CFG, 0, 1, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 1, 5, 1, 1, BY_MODEL, scef_pkg::VERDICT_INVALID);
		// count past the cap, field extremes
		add_step(127, 0, 63, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 63, 0, 1, 1, KNOWN, scef_pkg::VERDICT_INVALID);
		add_step(64, 63, 63, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 63, 0, 1, 0, BY_MODEL, scef_pkg::VERDICT_INVALID);
		add_step(NO_CFG, 0, 63, 1, 1, KNOWN, scef_pkg::VERDICT_INVALID);
		add_step(1, 63, 63, 1, 1, KNOWN, scef_pkg::VERDICT_CONNECTED);
		add_step(65, 0, 0, 0, 1, KNOWN, scef_pkg::VERDICT_INVALID);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].set_cfg) set_nodes(plan[r].cfg);
			push_item(plan[r].it, plan[r].typed, plan[r].want);
		end

		// random graphs, idling switched per graph so some run back to back
		while (counted < ITEM_GOAL) begin
			gaps_on = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			if (!overflow_done && counted >= ITEM_GOAL / 2) begin
				overflow_graph();
				overflow_done = 1'b1;
			end else begin
				if ($urandom_range(0, 2) == 0) set_nodes(pick_setting());
				random_graph();
			end
		end

		item_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
rtl/scef_pkg.sv
rtl/scef_ram.sv
rtl/strong_connectivity_edge_flip.sv
rtl/scef_checker.sv
tb/strong_connectivity_edge_flip_test.sv
